[rtl/tslm_pkg.sv]
// Package for the three-stage latency matcher.
// Holds field widths, function and stage codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tslm_pkg;

	localparam int QUEUE_LIMIT_DEF = 1024;
	localparam int STAMP_W = 63;
	localparam int SUM_W = 64;
	localparam int NUM_STAGES = 3;
	localparam int STAGE_W = 2;

	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_REPORT = 1'b1;

	localparam logic [STAGE_W-1:0] STAGE_CAPTURE = 2'd0;
	localparam logic [STAGE_W-1:0] STAGE_ENCODE = 2'd1;
	localparam logic [STAGE_W-1:0] STAGE_PUSH = 2'd2;
	localparam logic [STAGE_W-1:0] STAGE_SPARE = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF0,
		ST_ACC0,
		ST_DIFF1,
		ST_ACC1,
		ST_DIFF2,
		ST_ACC2
	} state_t;

endpackage

`default_nettype wire

[rtl/three_stage_latency_matcher_core.sv]
// Top level of the three-stage latency matcher: three stamp FIFOs and the sum sequencer.
// Depends on tslm_pkg and tslm_ram.
`timescale 1ns / 1ps
`default_nettype none

// A stamp item goes into the FIFO of its stage; when all three FIFOs hold an entry their
// heads are matched and the three latency differences are added to wrapping sums. A report
// item returns the sums and the frame count and clears them. Every item gives exactly one
// result, shown for one cycle with done high, in the cycle after the item is accepted for a
// report, a stamp that matches nothing, or an overflow resync; the receiver cannot hold it
// off. A matching stamp keeps busy high through DIFF0, ACC0, DIFF1, ACC1, DIFF2 and ACC2
// while one shared 64-bit adder forms each difference and adds it to its sum; its result
// follows ACC2. The FIFO memories need no clearing after reset.
module three_stage_latency_matcher_core #(
	parameter int QUEUE_LIMIT = tslm_pkg::QUEUE_LIMIT_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic                               func,
	input  wire logic [tslm_pkg::STAGE_W-1:0]       stage,
	input  wire logic [tslm_pkg::STAMP_W-1:0]       stamp_time,
	output logic                                    done,
	output logic                                    matched,
	output logic                                    resynced,
	output logic signed [tslm_pkg::SUM_W-1:0]       capture_encode_sum,
	output logic signed [tslm_pkg::SUM_W-1:0]       encode_push_sum,
	output logic signed [tslm_pkg::SUM_W-1:0]       capture_push_sum,
	output logic        [tslm_pkg::SUM_W-1:0]       frames_matched
);

	localparam int PTR_W = $clog2(QUEUE_LIMIT);
	localparam int OCC_W = $clog2(QUEUE_LIMIT + 1);
	localparam int NS = tslm_pkg::NUM_STAGES;
	localparam int SW = tslm_pkg::SUM_W;
	localparam int TW = tslm_pkg::STAMP_W;
	localparam int STW = tslm_pkg::STAGE_W;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_LIMIT - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	tslm_pkg::state_t state_q, state_d;

	logic [OCC_W-1:0] occ_q [NS];
	logic [PTR_W-1:0] head_q [NS];
	logic [PTR_W-1:0] tail_q [NS];
	logic [SW-1:0]    sum_q [NS];
	logic [SW-1:0]    cnt_q;
	logic [SW-1:0]    diff_q;
	logic [STW-1:0]   stage_q;
	logic [TW-1:0]    stamp_q;

	logic             done_q, matched_q, resynced_q;
	logic [SW-1:0]    ce_q, ep_q, cp_q, fm_q;

	logic             accept;
	logic [STW-1:0]   st_in;
	logic             full;
	logic             match_in;
	logic [NS-1:0]    ram_we;
	logic [TW-1:0]    rd_data [NS];
	logic [TW-1:0]    head_val [NS];

	logic [SW-1:0]    add_a, add_b, add_res;
	logic             add_cin;

	assign busy = (state_q != tslm_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign st_in = (stage == tslm_pkg::STAGE_SPARE) ? tslm_pkg::STAGE_PUSH : stage;
	assign full = (occ_q[st_in] == OCC_W'(QUEUE_LIMIT));

	always_comb begin
		match_in = !full;
		for (int s = 0; s < NS; s++) begin
			if (st_in != STW'(s) && occ_q[s] == '0) begin
				match_in = 1'b0;
			end
		end
	end

	for (genvar g = 0; g < NS; g++) begin : g_fifo
		assign ram_we[g] = accept && (func == tslm_pkg::FUNC_RECORD) && !full && !match_in
			&& (st_in == STW'(g));

		tslm_ram #(
			.WIDTH(TW),
			.DEPTH(QUEUE_LIMIT)
		) u_ram (
			.clk  (clk),
			.we   (ram_we[g]),
			.waddr(tail_q[g]),
			.wdata(stamp_time),
			.re   (accept && (func == tslm_pkg::FUNC_RECORD) && match_in),
			.raddr(head_q[g]),
			.rdata(rd_data[g])
		);

		// The stage that completed the match was empty, so its head is the stamp itself.
		assign head_val[g] = (stage_q == STW'(g)) ? stamp_q : rd_data[g];
	end

	always_comb begin
		add_a = '0;
		add_b = '0;
		add_cin = 1'b0;
		state_d = state_q;
		case (state_q)
			tslm_pkg::ST_IDLE: begin
				if (accept && (func == tslm_pkg::FUNC_RECORD) && match_in) begin
					state_d = tslm_pkg::ST_DIFF0;
				end
			end
			tslm_pkg::ST_DIFF0: begin
				add_a = {1'b0, head_val[1]};
				add_b = ~{1'b0, head_val[0]};
				add_cin = 1'b1;
				state_d = tslm_pkg::ST_ACC0;
			end
			tslm_pkg::ST_ACC0: begin
				add_a = sum_q[0];
				add_b = diff_q;
				state_d = tslm_pkg::ST_DIFF1;
			end
			tslm_pkg::ST_DIFF1: begin
				add_a = {1'b0, head_val[2]};
				add_b = ~{1'b0, head_val[1]};
				add_cin = 1'b1;
				state_d = tslm_pkg::ST_ACC1;
			end
			tslm_pkg::ST_ACC1: begin
				add_a = sum_q[1];
				add_b = diff_q;
				state_d = tslm_pkg::ST_DIFF2;
			end
			tslm_pkg::ST_DIFF2: begin
				add_a = {1'b0, head_val[2]};
				add_b = ~{1'b0, head_val[0]};
				add_cin = 1'b1;
				state_d = tslm_pkg::ST_ACC2;
			end
			tslm_pkg::ST_ACC2: begin
				add_a = sum_q[2];
				add_b = diff_q;
				state_d = tslm_pkg::ST_IDLE;
			end
			default: begin
				state_d = tslm_pkg::ST_IDLE;
			end
		endcase
	end

	assign add_res = add_a + add_b + {{(SW-1){1'b0}}, add_cin};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tslm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NS; s++) begin
				occ_q[s] <= '0;
				head_q[s] <= '0;
				tail_q[s] <= '0;
				sum_q[s] <= '0;
			end
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && !(func == tslm_pkg::FUNC_RECORD && match_in))
				|| (state_q == tslm_pkg::ST_ACC2);
			if (accept && func == tslm_pkg::FUNC_REPORT) begin
				if (cnt_q != '0) begin
					for (int s = 0; s < NS; s++) begin
						sum_q[s] <= '0;
					end
					cnt_q <= '0;
				end
			end else if (accept && full) begin
				for (int s = 0; s < NS; s++) begin
					occ_q[s] <= '0;
					head_q[s] <= '0;
					tail_q[s] <= '0;
				end
			end else if (accept && match_in) begin
				for (int s = 0; s < NS; s++) begin
					head_q[s] <= ptr_inc(head_q[s]);
					if (st_in == STW'(s)) begin
						tail_q[s] <= ptr_inc(tail_q[s]);
					end else begin
						occ_q[s] <= occ_q[s] - OCC_W'(1);
					end
				end
			end else if (accept) begin
				for (int s = 0; s < NS; s++) begin
					if (st_in == STW'(s)) begin
						tail_q[s] <= ptr_inc(tail_q[s]);
						occ_q[s] <= occ_q[s] + OCC_W'(1);
					end
				end
			end
			case (state_q)
				tslm_pkg::ST_ACC0: begin
					sum_q[0] <= add_res;
				end
				tslm_pkg::ST_ACC1: begin
					sum_q[1] <= add_res;
				end
				tslm_pkg::ST_ACC2: begin
					sum_q[2] <= add_res;
					cnt_q <= cnt_q + SW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_q <= st_in;
			stamp_q <= stamp_time;
			matched_q <= 1'b0;
			resynced_q <= (func == tslm_pkg::FUNC_RECORD) && full;
			ce_q <= sum_q[0];
			ep_q <= sum_q[1];
			cp_q <= sum_q[2];
			fm_q <= cnt_q;
		end
		case (state_q)
			tslm_pkg::ST_DIFF0, tslm_pkg::ST_DIFF1, tslm_pkg::ST_DIFF2: begin
				diff_q <= add_res;
			end
			tslm_pkg::ST_ACC2: begin
				matched_q <= 1'b1;
				resynced_q <= 1'b0;
				ce_q <= sum_q[0];
				ep_q <= sum_q[1];
				cp_q <= add_res;
				fm_q <= cnt_q + SW'(1);
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign matched = matched_q;
	assign resynced = resynced_q;
	assign capture_encode_sum = $signed(ce_q);
	assign encode_push_sum = $signed(ep_q);
	assign capture_push_sum = $signed(cp_q);
	assign frames_matched = fm_q;

	a_never_all_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(occ_q[0] != '0 && occ_q[1] != '0 && occ_q[2] != '0))
		else $error("all three stamp FIFOs hold entries at once");

	a_resync_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(done && resynced) |-> (occ_q[0] == '0 && occ_q[1] == '0 && occ_q[2] == '0))
		else $error("resync result without flushed FIFOs");

	a_report_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == tslm_pkg::FUNC_REPORT) |=> (done && !matched && !resynced))
		else $error("report item gave no plain result in the next cycle");

	a_match_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(done && matched) |-> ($past(state_q) == tslm_pkg::ST_ACC2))
		else $error("matched result not produced by the final accumulate step");

endmodule

`default_nettype wire

[rtl/tslm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tslm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
